FILE: design/accel_tilt_angle_setpoint_macros.svh
// assertion macros for the tilt angle setpoint block
// used by the top level; no other dependencies
`ifndef ACCEL_TILT_ANGLE_SETPOINT_MACROS_SVH
`define ACCEL_TILT_ANGLE_SETPOINT_MACROS_SVH
`ifndef SYNTHESIS
`define ATSP_CHECK(lbl, clk, rst, prop, msg) lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATSP_CHECK_ALWAYS(lbl, clk, prop, msg) lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATSP_CHECK(lbl, clk, rst, prop, msg)
`define ATSP_CHECK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/atsp_pkg.sv
// shared constants, types and the arctangent table for the tilt angle block
// no dependencies
package atsp_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ISQ_STAGES    = 31;
   localparam int LANE_LAT      = ISQ_STAGES + CORDIC_STAGES + 1;
   localparam int FRONT_LAT     = 4;
   localparam int TOTAL_LAT     = FRONT_LAT + LANE_LAT + 1;

   localparam int RSQ_W = 61;
   localparam int NUM_W = 31;
   localparam int MAG_W = 30;
   localparam int ISQ_W = 62;
   localparam int CXY_W = 35;
   localparam int CZ_W  = 25;

   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;

   typedef enum logic [1:0] {
      REG_TARGET = 2'd0,
      REG_TOL    = 2'd1,
      REG_SPEED  = 2'd2
   } csr_index_type;

   // atan(2^-i) in degrees, scaled by 2^16
   function automatic logic signed [CZ_W-1:0] atan_entry(input int idx);
      logic signed [CZ_W-1:0] v;
      begin
         case (idx)
            0: v = 25'sd2949120;
            1: v = 25'sd1740967;
            2: v = 25'sd919879;
            3: v = 25'sd466945;
            4: v = 25'sd234379;
            5: v = 25'sd117304;
            6: v = 25'sd58671;
            7: v = 25'sd29335;
            8: v = 25'sd14668;
            9: v = 25'sd7334;
            10: v = 25'sd3667;
            11: v = 25'sd1833;
            12: v = 25'sd917;
            13: v = 25'sd458;
            14: v = 25'sd229;
            15: v = 25'sd115;
            16: v = 25'sd57;
            17: v = 25'sd29;
            18: v = 25'sd14;
            19: v = 25'sd7;
            20: v = 25'sd4;
            21: v = 25'sd2;
            22: v = 25'sd1;
            default: v = 25'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

FILE: design/atsp_angle_lane.sv
// one angle lane: pipelined integer square root then cordic vectoring
// depends on atsp_pkg
module atsp_angle_lane (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic [atsp_pkg::RSQ_W-1:0]           rad_sq,
   input  logic signed [atsp_pkg::NUM_W-1:0]    num,
   output logic signed [15:0]                   angle
);

   localparam int IS = atsp_pkg::ISQ_STAGES;
   localparam int CS = atsp_pkg::CORDIC_STAGES;
   localparam int IW = atsp_pkg::ISQ_W;
   localparam int XW = atsp_pkg::CXY_W;
   localparam int ZW = atsp_pkg::CZ_W;

   logic [IW-1:0]                     rem_ff [IS];
   logic [IW-1:0]                     res_ff [IS];
   logic signed [atsp_pkg::NUM_W-1:0] num_ff [IS];
   logic signed [XW-1:0]              cx_ff  [CS];
   logic signed [XW-1:0]              cy_ff  [CS];
   logic signed [ZW-1:0]              cz_ff  [CS];
   logic signed [15:0]                angle_ff;

   genvar i;
   generate
      for (i = 0; i < IS; i++) begin : g_isq
         localparam logic [IW-1:0] BITV = IW'(1) << (2 * (IS - 1 - i));
         logic [IW-1:0]                     rem_prev, res_prev, trial;
         logic signed [atsp_pkg::NUM_W-1:0] num_prev;
         if (i == 0) begin : g_first
            assign rem_prev = IW'(rad_sq);
            assign res_prev = '0;
            assign num_prev = num;
         end else begin : g_rest
            assign rem_prev = rem_ff[i-1];
            assign res_prev = res_ff[i-1];
            assign num_prev = num_ff[i-1];
         end
         assign trial = res_prev + BITV;
         always_ff @(posedge clock) begin
            if (adv) begin
               num_ff[i] <= num_prev;
               if (rem_prev >= trial) begin
                  rem_ff[i] <= rem_prev - trial;
                  res_ff[i] <= (res_prev >> 1) + BITV;
               end else begin
                  rem_ff[i] <= rem_prev;
                  res_ff[i] <= res_prev >> 1;
               end
            end
         end
      end

      for (i = 0; i < CS; i++) begin : g_cordic
         localparam logic signed [ZW-1:0] TV = atsp_pkg::atan_entry(i);
         logic signed [XW-1:0] x_prev, y_prev, dx, dy;
         logic signed [ZW-1:0] z_prev;
         if (i == 0) begin : g_first
            assign x_prev = $signed({{(XW-atsp_pkg::NUM_W){1'b0}},
                                     res_ff[IS-1][atsp_pkg::NUM_W-1:0]});
            assign y_prev = XW'(num_ff[IS-1]);
            assign z_prev = '0;
         end else begin : g_rest
            assign x_prev = cx_ff[i-1];
            assign y_prev = cy_ff[i-1];
            assign z_prev = cz_ff[i-1];
         end
         assign dx = y_prev >>> i;
         assign dy = x_prev >>> i;
         always_ff @(posedge clock) begin
            if (adv) begin
               if (!y_prev[XW-1]) begin
                  cx_ff[i] <= x_prev + dx;
                  cy_ff[i] <= y_prev - dy;
                  cz_ff[i] <= z_prev + TV;
               end else begin
                  cx_ff[i] <= x_prev - dx;
                  cy_ff[i] <= y_prev + dy;
                  cz_ff[i] <= z_prev - TV;
               end
            end
         end
      end
   endgenerate

   logic signed [ZW-1:0] z_rnd;
   logic signed [ZW-9:0] q_w;
   logic signed [15:0]   angle_in;

   always_comb begin
      z_rnd = cz_ff[CS-1] + ZW'(128);
      q_w   = z_rnd[ZW-1:8];
      if (q_w > (ZW-8)'(atsp_pkg::ANGLE_LIMIT)) begin
         angle_in = atsp_pkg::ANGLE_LIMIT;
      end else if (q_w < -(ZW-8)'(atsp_pkg::ANGLE_LIMIT)) begin
         angle_in = -atsp_pkg::ANGLE_LIMIT;
      end else begin
         angle_in = q_w[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

FILE: design/accel_tilt_angle_setpoint.sv
// Tilt angle setpoint: roll and pitch from one accelerometer item, roll checked
// against a target. Pipeline in order: normalise, split squares, sums, one
// square-root bit per stage, one cordic stage per stage, round, compare.
// Throughput one item per cycle; a stalled output freezes the whole pipeline.
// Synchronous reset clears valid bits and restores the register defaults.
`include "accel_tilt_angle_setpoint_macros.svh"
module accel_tilt_angle_setpoint (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // roll_angle, pitch_angle, drive_command, at_target
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int TL = atsp_pkg::TOTAL_LAT;
   localparam int LO = atsp_pkg::FRONT_LAT + atsp_pkg::LANE_LAT - 1;
   localparam int MW = atsp_pkg::MAG_W;

   logic signed [15:0] target_ff;
   logic [15:0]        tol_ff;
   logic signed [15:0] speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 16'sd0;
         tol_ff    <= 16'd256;
         speed_ff  <= 16'sd8192;
      end else if (csr_we) begin
         unique case (csr_addr)
            atsp_pkg::REG_TARGET: target_ff <= csr_wdata;
            atsp_pkg::REG_TOL:    tol_ff    <= csr_wdata;
            atsp_pkg::REG_SPEED:  speed_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic          adv;
   logic [TL-1:0] valid_ff;
   logic [TL-1:0] zero_ff;

   assign adv        = !valid_ff[TL-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[TL-1];

   // normalise
   logic signed [15:0]                acc    [3];
   logic [15:0]                       mag    [3];
   logic [15:0]                       big;
   logic [3:0]                        msb;
   logic [4:0]                        sh;
   logic [MW-1:0]                     mag_in [3];
   logic signed [atsp_pkg::NUM_W-1:0] num_in [2];
   logic                              zero_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k] = req_tdata[16*k +: 16];
         mag[k] = acc[k][15] ? 16'(-acc[k]) : 16'(acc[k]);
      end
      big = mag[0];
      if (mag[1] > big) big = mag[1];
      if (mag[2] > big) big = mag[2];
      msb = '0;
      for (int k = 0; k < 16; k++) begin
         if (big[k]) msb = 4'(k);
      end
      sh = 5'd29 - {1'b0, msb};
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = {{(MW-16){1'b0}}, mag[k]} << sh;
      end
      for (int k = 0; k < 2; k++) begin
         num_in[k] = atsp_pkg::NUM_W'(acc[k]) <<< sh;
      end
      zero_in = (big == 16'd0);
   end

   logic [MW-1:0]                     mag_ff  [3];
   logic [29:0]                       hh_ff   [3];
   logic [29:0]                       hl_ff   [3];
   logic [29:0]                       ll_ff   [3];
   logic [59:0]                       sq_ff   [3];
   logic [atsp_pkg::RSQ_W-1:0]        nyz_ff, nxz_ff;
   logic signed [atsp_pkg::NUM_W-1:0] num1_ff [2];
   logic signed [atsp_pkg::NUM_W-1:0] num2_ff [2];
   logic signed [atsp_pkg::NUM_W-1:0] num3_ff [2];
   logic signed [atsp_pkg::NUM_W-1:0] num4_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            mag_ff[k] <= mag_in[k];
            hh_ff[k]  <= 30'(mag_ff[k][29:15]) * 30'(mag_ff[k][29:15]);
            hl_ff[k]  <= 30'(mag_ff[k][29:15]) * 30'(mag_ff[k][14:0]);
            ll_ff[k]  <= 30'(mag_ff[k][14:0]) * 30'(mag_ff[k][14:0]);
            sq_ff[k]  <= (60'(hh_ff[k]) << 30) + (60'(hl_ff[k]) << 16) + 60'(ll_ff[k]);
         end
         nyz_ff <= atsp_pkg::RSQ_W'(sq_ff[1]) + atsp_pkg::RSQ_W'(sq_ff[2]);
         nxz_ff <= atsp_pkg::RSQ_W'(sq_ff[0]) + atsp_pkg::RSQ_W'(sq_ff[2]);
         for (int k = 0; k < 2; k++) begin
            num1_ff[k] <= num_in[k];
            num2_ff[k] <= num1_ff[k];
            num3_ff[k] <= num2_ff[k];
            num4_ff[k] <= num3_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[TL-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= {zero_ff[TL-2:0], zero_in};
      end
   end

   logic signed [15:0] roll_raw, pitch_raw;

   atsp_angle_lane u_roll (
      .clock  (clock),
      .adv    (adv),
      .rad_sq (nyz_ff),
      .num    (num4_ff[0]),
      .angle  (roll_raw)
   );

   atsp_angle_lane u_pitch (
      .clock  (clock),
      .adv    (adv),
      .rad_sq (nxz_ff),
      .num    (num4_ff[1]),
      .angle  (pitch_raw)
   );

   // setpoint check
   logic signed [15:0] roll_in, pitch_in;
   logic signed [16:0] err;
   logic [16:0]        err_abs;
   logic               done_in;

   always_comb begin
      roll_in  = zero_ff[LO] ? 16'sd0 : -roll_raw;
      pitch_in = zero_ff[LO] ? 16'sd0 : pitch_raw;
      err      = 17'(roll_in) - 17'(target_ff);
      err_abs  = err[16] ? 17'(-err) : 17'(err);
      done_in  = !(err_abs > {1'b0, tol_ff});
   end

   logic signed [15:0] roll_ff, pitch_ff, drive_ff;
   logic               at_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         drive_ff <= done_in ? 16'sd0 : speed_ff;
         at_ff    <= done_in;
      end
   end

   assign rsp_tdata = {7'd0, at_ff, drive_ff, pitch_ff, roll_ff};

   `ATSP_CHECK(a_done_no_drive, clock, reset, rsp_tvalid && at_ff |-> drive_ff == 16'sd0, "drive while at target")
   `ATSP_CHECK(a_roll_range, clock, reset, rsp_tvalid |-> roll_ff <= atsp_pkg::ANGLE_LIMIT && roll_ff >= -atsp_pkg::ANGLE_LIMIT, "roll out of range")
   `ATSP_CHECK(a_stall_freeze, clock, reset, !adv |=> $stable(valid_ff), "pipeline moved during stall")
   `ATSP_CHECK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

FILE: test/accel_tilt_angle_setpoint_checker.sv
// checker for the tilt angle setpoint block: watches both item channels,
// predicts roll, pitch, drive and done flag, and compares; uses atsp_pkg
module accel_tilt_angle_setpoint_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic        done;
      logic [15:0] drive;
      logic [15:0] pitch;
      logic [15:0] roll;
   } tilt_result_type;

   localparam longint TURN_Q16[24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   logic signed [15:0] target_q;
   logic [15:0]        tol_q;
   logic signed [15:0] speed_q;
   tilt_result_type    expected_q[$];

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint n);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint tilt_deg(longint a, longint r);
      longint x, y, z, dx, dy, q;
      x = r; y = a; z = 0;
      for (int i = 0; i < atsp_pkg::CORDIC_STAGES && i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += TURN_Q16[i];
         end else begin
            x -= dx; y += dy; z -= TURN_Q16[i];
         end
      end
      q = floor_shift(z + 128, 8);
      if (q > 23040) q = 23040;
      if (q < -23040) q = -23040;
      return q;
   endfunction

   function automatic tilt_result_type predict_tilt(logic [47:0] d);
      tilt_result_type res;
      longint ax, ay, az, mx, my, mz, big, roll, pitch, err;
      ax = longint'($signed(d[15:0]));
      ay = longint'($signed(d[31:16]));
      az = longint'($signed(d[47:32]));
      mx = ax < 0 ? -ax : ax;
      my = ay < 0 ? -ay : ay;
      mz = az < 0 ? -az : az;
      big = mx > my ? mx : my;
      if (mz > big) big = mz;
      roll = 0; pitch = 0;
      if (big != 0) begin
         while (big < (64'sd1 <<< 29)) begin
            big *= 2; mx *= 2; my *= 2; mz *= 2; ax *= 2; ay *= 2; az *= 2;
         end
         roll = -tilt_deg(ax, root_floor(my * my + mz * mz));
         pitch = tilt_deg(ay, root_floor(mx * mx + mz * mz));
      end
      err = roll - longint'(target_q);
      if (err < 0) err = -err;
      res.roll = roll[15:0];
      res.pitch = pitch[15:0];
      res.done = !(err > longint'(tol_q));
      res.drive = res.done ? 16'd0 : speed_q;
      return res;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      tilt_result_type got, exp_r;
      if (reset) begin
         target_q <= 16'sd0;
         tol_q <= 16'd256;
         speed_q <= 16'sd8192;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_q.push_back(predict_tilt(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[48:0];
            if (expected_q.size() == 0) begin
               $error("unexpected item %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got.roll !== exp_r.roll) $error("roll_angle exp %0d got %0d",
                  $signed(exp_r.roll), $signed(got.roll));
               if (got.pitch !== exp_r.pitch) $error("pitch_angle exp %0d got %0d",
                  $signed(exp_r.pitch), $signed(got.pitch));
               if (got.drive !== exp_r.drive) $error("drive_command exp %0d got %0d",
                  $signed(exp_r.drive), $signed(got.drive));
               if (got.done !== exp_r.done) $error("at_target exp %0b got %0b",
                  exp_r.done, got.done);
               if (got !== exp_r) fail_count <= fail_count + 1;
            end
         end
         if (csr_we) begin
            case (csr_addr)
               atsp_pkg::REG_TARGET: target_q <= csr_wdata;
               atsp_pkg::REG_TOL:    tol_q <= csr_wdata;
               atsp_pkg::REG_SPEED:  speed_q <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

FILE: test/accel_tilt_angle_setpoint_tb.sv
// top of the tilt angle setpoint testbench: clock, reset, stimulus, verdict
// depends on atsp_pkg, the block and accel_tilt_angle_setpoint_checker
module accel_tilt_angle_setpoint_tb;

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready, csr_we;
   logic [47:0] req_tdata;
   logic [55:0] rsp_tdata;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;
   int          fail_count, pending, cycles;
   bit          calm;

   accel_tilt_angle_setpoint dut (.*);
   accel_tilt_angle_setpoint_checker chk (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 400000) begin
            $display("accel_tilt_angle_setpoint_tb: done, errors");
            $finish;
         end
      end
   end

   // output stall bursts
   initial begin
      int n;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // enable is dropped by the caller once all writes are done
   task automatic write_reg(atsp_pkg::csr_index_type idx, logic [15:0] v);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= v;
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (atsp_pkg::TOTAL_LAT + 4) @(negedge clock);
   endtask

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 40) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] ext[6];
      ext = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h1234};
      calm = 0;
      reset = 1; req_tvalid = 0; req_tdata = '0; csr_we = 0; csr_addr = '0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset = 0;
      // directed: zero vector, zero radius, axis extremes
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7fff, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h7fff, 16'h0000);
      send_sample(16'h0000, 16'h8000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff);
      for (int i = 0; i < 12; i++)
         send_sample(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)], ext[i % 6]);
      drain_pipe();
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin write_reg(atsp_pkg::REG_TARGET, 16'sd23040);
               write_reg(atsp_pkg::REG_TOL, 16'd0);
               write_reg(atsp_pkg::REG_SPEED, 16'h7fff); end
            1: begin write_reg(atsp_pkg::REG_TARGET, -16'sd23040);
               write_reg(atsp_pkg::REG_TOL, 16'd46080);
               write_reg(atsp_pkg::REG_SPEED, 16'h8000); end
            2: begin write_reg(atsp_pkg::REG_TARGET, 16'sd0);
               write_reg(atsp_pkg::REG_TOL, 16'd65535);
               write_reg(atsp_pkg::REG_SPEED, 16'hffff); end
            3: write_reg(atsp_pkg::REG_TOL, 16'hffff);
            4: ;
            default: begin
               write_reg(atsp_pkg::REG_TARGET, 16'($urandom_range(0, 46080) - 23040));
               write_reg(atsp_pkg::REG_TOL, 16'($urandom_range(0, 4000)));
               write_reg(atsp_pkg::REG_SPEED, 16'($urandom));
               write_reg(atsp_pkg::csr_index_type'(2'd3), 16'($urandom));
            end
         endcase
         csr_we <= 0;
         if (ph == 6) calm = 1;
         for (int i = 0; i < 150; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
         drain_pipe();
      end
      if (fail_count == 0)
         $display("accel_tilt_angle_setpoint_tb: done, clean");
      else
         $display("accel_tilt_angle_setpoint_tb: done, errors");
      $finish;
   end
endmodule
